// File: hdl/imh_pkg.sv
// Shared types and constants for the indexed min-heap priority queue.
package imh_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int ID_BITS_DEF      = 8;
  localparam int KEY_BITS_DEF     = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_SET_KEY = 2'd1;
  localparam logic [1:0] KIND_DEL_MIN = 2'd2;
  localparam logic [1:0] KIND_REMOVE  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DUP       = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,      // capture command, read position table
    OP_CHECK,      // evaluate command against count and position
    OP_RD_POS,     // read heap slot at pos
    OP_GRAB,       // latch slot data as the taken-out or old entry
    OP_RD_LAST,    // read last slot
    OP_MOVE_LAST,  // take last slot as moving entry, clear old id
    OP_RD_PARENT,  // read parent slot
    OP_UP_STEP,    // compare with parent, move parent down or stop
    OP_RD_LEFT,    // read left child
    OP_RD_RIGHT,   // capture left, read right child
    OP_DN_STEP,    // pick child, move it up or stop
    OP_PLACE,      // write moving entry to its final slot
    OP_DONE        // present result
  } op_t;

  typedef struct packed {
    logic       is_insert;
    logic       fail;        // command rejected, status already set
    logic       at_root;     // pos == 1
    logic       has_child;   // 2*pos <= count
    logic       go_up;       // compare says move toward root
    logic       dn_move;     // compare says move toward leaves
    logic       pos_is_last; // removed slot is the last one
  } dp_status_t;

endpackage

// File: hdl/imh_ram.sv
// Generic single-port RAM with registered read.
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: hdl/imh_ctrl.sv
// Command sequencer for the indexed min-heap.
module imh_ctrl import imh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] kind,
  input  logic       clear_done,
  input  dp_status_t st,
  output logic       busy,
  output op_t        op
);
  typedef enum logic [13:0] {
    S_CLEAR   = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_CHECK   = 14'b00000000000100,
    S_RD_POS  = 14'b00000000001000,
    S_GRAB    = 14'b00000000010000,
    S_RD_LAST = 14'b00000000100000,
    S_MV_LAST = 14'b00000001000000,
    S_RD_PAR  = 14'b00000010000000,
    S_UP      = 14'b00000100000000,
    S_RD_L    = 14'b00001000000000,
    S_RD_R    = 14'b00010000000000,
    S_DN      = 14'b00100000000000,
    S_PLACE   = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic   drop;  // delete/remove path: move last into hole
  logic   drop_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      drop  <= 1'b0;
    end else begin
      state <= state_next;
      drop  <= drop_next;
    end
  end

  // Entry into sift: up if not at root and smaller than parent, decided in S_UP.
  always_comb begin
    state_next = state;
    drop_next  = drop;
    op         = OP_NONE;
    busy       = 1'b1;
    case (state)
      S_CLEAR: begin
        if (clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          op = OP_LATCH;
          state_next = S_CHECK;
          drop_next = (kind == KIND_DEL_MIN) || (kind == KIND_REMOVE);
        end
      end
      S_CHECK: begin
        op = OP_CHECK;
        if (st.fail) state_next = S_DONE;
        else if (st.is_insert) state_next = S_RD_PAR;
        else state_next = S_RD_POS;
      end
      S_RD_POS: begin
        op = OP_RD_POS;
        state_next = S_GRAB;
      end
      S_GRAB: begin
        op = OP_GRAB;
        if (drop) state_next = S_RD_LAST;
        else state_next = S_RD_PAR;
      end
      S_RD_LAST: begin
        op = OP_RD_LAST;
        state_next = S_MV_LAST;
      end
      S_MV_LAST: begin
        op = OP_MOVE_LAST;
        if (st.pos_is_last) state_next = S_DONE;
        else state_next = S_RD_PAR;
      end
      S_RD_PAR: begin
        if (st.at_root) begin
          state_next = S_RD_L;
        end else begin
          op = OP_RD_PARENT;
          state_next = S_UP;
        end
      end
      S_UP: begin
        op = OP_UP_STEP;
        if (st.go_up) state_next = S_RD_PAR;
        else if (st.is_insert) state_next = S_PLACE;
        else state_next = S_RD_L;
      end
      S_RD_L: begin
        if (!st.has_child) begin
          state_next = S_PLACE;
        end else begin
          op = OP_RD_LEFT;
          state_next = S_RD_R;
        end
      end
      S_RD_R: begin
        op = OP_RD_RIGHT;
        state_next = S_DN;
      end
      S_DN: begin
        op = OP_DN_STEP;
        if (st.dn_move) state_next = S_RD_L;
        else state_next = S_PLACE;
      end
      S_PLACE: begin
        op = OP_PLACE;
        state_next = S_DONE;
      end
      S_DONE: begin
        op = OP_DONE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: hdl/imh_dp.sv
// Heap storage, position table and compare datapath.
module imh_dp import imh_pkg::*; #(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int ID_BITS      = ID_BITS_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  op_t                     op,
  input  logic [1:0]              kind,
  input  logic [ID_BITS-1:0]      id,
  input  logic [KEY_BITS-1:0]     key,
  input  logic [PAYLOAD_BITS-1:0] payload,
  output logic                    clear_done,
  output dp_status_t              st,
  output logic                    done,
  output logic [2:0]              status,
  output logic [ID_BITS-1:0]      out_id,
  output logic [KEY_BITS-1:0]     out_key,
  output logic [PAYLOAD_BITS-1:0] out_payload
);
  localparam int PW    = $clog2(CAPACITY + 1);  // slot number 0..CAPACITY
  localparam int AW    = $clog2(CAPACITY);
  localparam int IDN   = 1 << ID_BITS;
  localparam int SW    = ID_BITS + KEY_BITS + PAYLOAD_BITS;
  localparam logic [PW-1:0] CAP = PW'(CAPACITY);

  // Slot word: {id, biased key, payload}
  logic            hp_we;
  logic [AW-1:0]   hp_addr;
  logic [SW-1:0]   hp_wdata, hp_rdata;
  logic            pt_we;
  logic [ID_BITS-1:0] pt_addr;
  logic [PW-1:0]   pt_wdata, pt_rdata;

  imh_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(hp_we), .addr(hp_addr), .wdata(hp_wdata), .rdata(hp_rdata));
  imh_ram #(.WIDTH(PW), .DEPTH(IDN)) u_pos (
    .clk(clk), .we(pt_we), .addr(pt_addr), .wdata(pt_wdata), .rdata(pt_rdata));

  logic [ID_BITS:0]      clr_cnt;
  logic [1:0]            cmd;
  logic [ID_BITS-1:0]    cid;
  logic [KEY_BITS-1:0]   ckey;       // biased
  logic [PAYLOAD_BITS-1:0] cpay;
  logic [PW-1:0]         count, pos, last;
  logic [ID_BITS-1:0]    m_id;       // moving entry
  logic [KEY_BITS-1:0]   m_key;
  logic [PAYLOAD_BITS-1:0] m_pay;
  logic [KEY_BITS-1:0]   old_key;
  logic [SW-1:0]         left;
  logic [2:0]            res;

  wire [ID_BITS-1:0]      r_id  = hp_rdata[SW-1 -: ID_BITS];
  wire [KEY_BITS-1:0]     r_key = hp_rdata[PAYLOAD_BITS +: KEY_BITS];
  wire [KEY_BITS-1:0]     l_key = left[PAYLOAD_BITS +: KEY_BITS];
  wire [PW:0]             pos2  = {pos, 1'b0};
  wire                    right_ok = (pos2 < {1'b0, count});
  wire                    pick_r = right_ok && (r_key < l_key);
  wire [SW-1:0]           child = pick_r ? hp_rdata : left;
  wire [PW-1:0]           child_pos = pick_r ? PW'(pos2 + 1'b1) : PW'(pos2);
  wire [KEY_BITS-1:0]     c_key = child[PAYLOAD_BITS +: KEY_BITS];
  wire [ID_BITS-1:0]      c_id  = child[SW-1 -: ID_BITS];

  assign clear_done = clr_cnt[ID_BITS];

  always_comb begin
    st = '0;
    st.is_insert   = (cmd == KIND_INSERT);
    st.at_root     = (pos == PW'(1));
    st.has_child   = (pos2 <= {1'b0, count});
    st.go_up       = (m_key < r_key) && (st.is_insert || !(old_key < m_key)
                     || cmd[1]);
    st.dn_move     = (m_key > c_key);
    st.pos_is_last = (pos == last);
    // check stage outcome
    st.fail = 1'b0;
    case (cmd)
      KIND_INSERT:  st.fail = (count >= CAP) || (pt_rdata != '0);
      KIND_SET_KEY: st.fail = (pt_rdata == '0);
      KIND_DEL_MIN: st.fail = (count == '0);
      default:      st.fail = (pt_rdata == '0);
    endcase
  end

  // Memory port steering.
  always_comb begin
    hp_we    = 1'b0;
    hp_addr  = AW'(pos - 1'b1);
    hp_wdata = {m_id, m_key, m_pay};
    pt_we    = 1'b0;
    pt_addr  = id;
    pt_wdata = pos;
    if (!clear_done) begin
      pt_we    = 1'b1;
      pt_addr  = clr_cnt[ID_BITS-1:0];
      pt_wdata = '0;
    end
    case (op)
      OP_LATCH: pt_addr = id;
      OP_RD_POS: hp_addr = AW'(pos - 1'b1);
      OP_RD_LAST: hp_addr = AW'(last - 1'b1);
      OP_MOVE_LAST: begin
        // drop the removed id from the table
        pt_we = 1'b1; pt_addr = cid; pt_wdata = '0;
      end
      OP_RD_PARENT: hp_addr = AW'((pos >> 1) - 1'b1);
      OP_UP_STEP: if (st.go_up) begin
        hp_we = 1'b1; hp_wdata = hp_rdata;
        pt_we = 1'b1; pt_addr = r_id; pt_wdata = pos;
      end
      OP_RD_LEFT: hp_addr = AW'(pos2 - 1'b1);
      OP_RD_RIGHT: hp_addr = AW'(pos2);
      OP_DN_STEP: if (st.dn_move) begin
        hp_we = 1'b1; hp_wdata = child;
        pt_we = 1'b1; pt_addr = c_id; pt_wdata = pos;
      end
      OP_PLACE: begin
        hp_we = 1'b1;
        pt_we = 1'b1; pt_addr = m_id; pt_wdata = pos;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done <= (op == OP_DONE);
      if (!clear_done) clr_cnt <= clr_cnt + 1'b1;
      case (op)
        OP_CHECK: if (!st.fail) begin
          if (cmd == KIND_INSERT) count <= count + 1'b1;
          else if (cmd[1]) count <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        cmd <= kind; cid <= id; ckey <= {~key[KEY_BITS-1], key[KEY_BITS-2:0]};
        cpay <= payload; res <= ST_OK;
        out_id <= '0; out_key <= '0; out_payload <= '0;
      end
      OP_CHECK: begin
        last <= count;
        case (cmd)
          KIND_INSERT: begin
            pos <= PW'(count + 1'b1);
            m_id <= cid; m_key <= ckey; m_pay <= cpay;
            if (count >= CAP) res <= ST_FULL;
            else if (pt_rdata != '0) res <= ST_DUP;
          end
          KIND_SET_KEY: begin
            pos <= pt_rdata;
            if (pt_rdata == '0) res <= ST_NOT_FOUND;
          end
          KIND_DEL_MIN: begin
            pos <= PW'(1);
            if (count == '0) res <= ST_EMPTY;
          end
          default: begin
            pos <= pt_rdata;
            if (pt_rdata == '0) res <= ST_NOT_FOUND;
          end
        endcase
      end
      OP_GRAB: begin
        m_id <= r_id; m_pay <= hp_rdata[PAYLOAD_BITS-1:0];
        old_key <= r_key;
        m_key <= ckey;  // set-key path uses new key
        cid <= r_id;
        if (cmd[1]) begin
          out_id <= r_id;
          out_key <= {~r_key[KEY_BITS-1], r_key[KEY_BITS-2:0]};
          out_payload <= hp_rdata[PAYLOAD_BITS-1:0];
        end
      end
      OP_MOVE_LAST: begin
        m_id <= r_id; m_key <= r_key; m_pay <= hp_rdata[PAYLOAD_BITS-1:0];
        old_key <= r_key;
      end
      OP_UP_STEP: if (st.go_up) pos <= pos >> 1;
      OP_RD_RIGHT: left <= hp_rdata;
      OP_DN_STEP: if (st.dn_move) pos <= child_pos;
      default: ;
    endcase
  end

  assign status = res;
endmodule

// File: hdl/indexed_min_heap_priority_queue.sv
// Top level of the indexed min-heap priority queue.
// One command at a time; busy drops in the result cycle, so the next item can
// be taken there. A rejected command goes from the check straight to the result.
// After rst the position table is cleared, one id per cycle, with busy high until
// every id is cleared. Results show for one cycle on done; the receiver cannot
// stall.
module indexed_min_heap_priority_queue import imh_pkg::*; #(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int ID_BITS      = ID_BITS_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              kind,
  input  logic [ID_BITS-1:0]      id,
  input  logic signed [KEY_BITS-1:0] key,
  input  logic [PAYLOAD_BITS-1:0] payload,
  output logic                    done,
  output logic [2:0]              status,
  output logic [ID_BITS-1:0]      out_id,
  output logic signed [KEY_BITS-1:0] out_key,
  output logic [PAYLOAD_BITS-1:0] out_payload
);
  op_t        op;
  dp_status_t st;
  logic       clear_done;

  // Sequence each command through the heap memory.
  imh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .kind(kind),
    .clear_done(clear_done), .st(st), .busy(busy), .op(op));

  // Hold heap, position table and the moving entry.
  imh_dp #(
    .CAPACITY(CAPACITY), .ID_BITS(ID_BITS),
    .KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .op(op), .kind(kind), .id(id), .key(key),
    .payload(payload), .clear_done(clear_done), .st(st), .done(done),
    .status(status), .out_id(out_id), .out_key(out_key),
    .out_payload(out_payload));
endmodule

// File: tb/testbench.sv
// Self-checking testbench for the indexed min-heap priority queue.
`timescale 1ns / 100ps

module testbench import imh_pkg::*;;

  localparam int CAP = CAPACITY_DEF;
  localparam int IDS = 1 << ID_BITS_DEF;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [31:0] key;
    logic [31:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  id;
    logic [31:0] key;
    logic [31:0] payload;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = KIND_INSERT;
  logic [7:0]  id = '0;
  logic signed [31:0] key = '0;
  logic [31:0] payload = '0;
  logic        done;
  logic [2:0]  status;
  logic [7:0]  out_id;
  logic signed [31:0] out_key;
  logic [31:0] out_payload;

  indexed_min_heap_priority_queue u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .id(id),
    .key(key), .payload(payload), .done(done), .status(status),
    .out_id(out_id), .out_key(out_key), .out_payload(out_payload)
  );

  always #1 clk = ~clk;

  // Shadow heap: slots 1..heap_size, keys kept signed.
  logic signed [31:0] hk [1:CAP];
  logic [7:0]         hid [1:CAP];
  logic [31:0]        hpay [1:CAP];
  int                 slot_of [IDS];
  int                 heap_size;

  cmd_t pending_cmds [$];
  res_t expected_results [$];
  int   errors;
  int   cycles;
  int   send_idle_pct;
  bit   stim_done;
  bit   hold_off;   // pause the sender while set
  logic took = 1'b0;

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] exp);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
    errors++;
  endtask

  function automatic void put(int p, logic signed [31:0] k, logic [7:0] i,
                              logic [31:0] d);
    hk[p] = k; hid[p] = i; hpay[p] = d; slot_of[i] = p;
  endfunction

  function automatic void bubble_up(int p);
    logic signed [31:0] k;
    logic [7:0] i;
    logic [31:0] d;
    k = hk[p]; i = hid[p]; d = hpay[p];
    while (p > 1 && k < hk[p/2]) begin
      put(p, hk[p/2], hid[p/2], hpay[p/2]);
      p = p / 2;
    end
    put(p, k, i, d);
  endfunction

  function automatic void bubble_down(int p);
    logic signed [31:0] k;
    logic [7:0] i;
    logic [31:0] d;
    int c;
    k = hk[p]; i = hid[p]; d = hpay[p];
    while (2 * p <= heap_size) begin
      c = 2 * p;
      if (c < heap_size && hk[c+1] < hk[c]) c++;
      if (!(k > hk[c])) break;
      put(p, hk[c], hid[c], hpay[c]);
      p = c;
    end
    put(p, k, i, d);
  endfunction

  // Work out the result of one command and update the shadow heap.
  function automatic res_t queue_step(cmd_t c);
    res_t r;
    int p;
    int last;
    logic signed [31:0] old;
    r = '0;
    r.status = ST_OK;
    case (c.kind)
      KIND_INSERT: begin
        if (heap_size >= CAP) r.status = ST_FULL;
        else if (slot_of[c.id] != 0) r.status = ST_DUP;
        else begin
          heap_size++;
          put(heap_size, c.key, c.id, c.payload);
          bubble_up(heap_size);
        end
      end
      KIND_SET_KEY: begin
        p = slot_of[c.id];
        if (p == 0) r.status = ST_NOT_FOUND;
        else begin
          old = hk[p];
          hk[p] = c.key;
          if (old < $signed(c.key)) bubble_down(p);
          else bubble_up(p);
        end
      end
      default: begin
        p = (c.kind == KIND_DEL_MIN) ? (heap_size > 0 ? 1 : 0) : slot_of[c.id];
        if (p == 0) r.status = (c.kind == KIND_DEL_MIN) ? ST_EMPTY : ST_NOT_FOUND;
        else begin
          r.id = hid[p]; r.key = hk[p]; r.payload = hpay[p];
          last = heap_size;
          slot_of[hid[p]] = 0;
          heap_size--;
          if (p != last) begin
            put(p, hk[last], hid[last], hpay[last]);
            if (p > 1 && hk[p] < hk[p/2]) bubble_up(p);
            else bubble_down(p);
          end
        end
      end
    endcase
    return r;
  endfunction

  // Driver: present the next item at the falling edge; hold it until taken.
  always @(negedge clk) begin
    if (!rst && (!start || took)) begin
      if (pending_cmds.size() > 0 && !hold_off &&
          $urandom_range(99) >= send_idle_pct) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        kind <= c.kind; id <= c.id; key <= c.key; payload <= c.payload;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Predict at the accepting edge and mark the item taken.
  always @(posedge clk) begin
    took <= !rst && start && !busy;
    if (!rst && start && !busy)
      expected_results.push_back(queue_step('{kind, id, key, payload}));
  end

  // Monitor: check each strobed result against the oldest expectation.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 32'(status), 32'd0);
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (status !== e.status) report("status", 32'(status), 32'(e.status));
        if (out_id !== e.id) report("out_id", 32'(out_id), 32'(e.id));
        if (out_key !== e.key) report("out_key", out_key, e.key);
        if (out_payload !== e.payload) report("out_payload", out_payload, e.payload);
      end
    end
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic cmd_t mk(logic [1:0] k, logic [7:0] i, logic [31:0] ky,
                              logic [31:0] d);
    cmd_t c;
    c.kind = k; c.id = i; c.key = ky; c.payload = d;
    return c;
  endfunction

  // Random key, often from a narrow range so that ties occur.
  function automatic logic [31:0] rand_key();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(8)) - 4);
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  // Random command; ids mostly from a small pool so hits are common.
  function automatic cmd_t rand_cmd(int fill_bias);
    logic [7:0] i;
    int r;
    i = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(79));
    r = $urandom_range(99);
    if (r < fill_bias) return mk(KIND_INSERT, i, rand_key(), $urandom());
    if (r < fill_bias + 20) return mk(KIND_SET_KEY, i, rand_key(), $urandom());
    if (r < fill_bias + 40) return mk(KIND_DEL_MIN, i, rand_key(), $urandom());
    return mk(KIND_REMOVE, i, rand_key(), $urandom());
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    heap_size = 0;
    hold_off = 1'b0;
    send_idle_pct = 24;
    foreach (slot_of[i]) slot_of[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: empty cases, extremes, ties, every command and special case.
    pending_cmds.push_back(mk(KIND_DEL_MIN, 8'd0, 32'd0, 32'd0));
    pending_cmds.push_back(mk(KIND_REMOVE, 8'd5, 32'd0, 32'd0));
    pending_cmds.push_back(mk(KIND_SET_KEY, 8'd5, 32'd0, 32'd0));
    pending_cmds.push_back(mk(KIND_INSERT, 8'hff, 32'h7fff_ffff, 32'hffff_ffff));
    pending_cmds.push_back(mk(KIND_INSERT, 8'h00, 32'h8000_0000, 32'h0));
    pending_cmds.push_back(mk(KIND_INSERT, 8'h00, 32'd1, 32'd1));
    pending_cmds.push_back(mk(KIND_INSERT, 8'haa, 32'd5, 32'h5555_aaaa));
    pending_cmds.push_back(mk(KIND_INSERT, 8'h55, 32'd5, 32'haaaa_5555));
    pending_cmds.push_back(mk(KIND_INSERT, 8'h11, 32'd5, 32'd7));
    pending_cmds.push_back(mk(KIND_SET_KEY, 8'h00, 32'd100, 32'd0));
    pending_cmds.push_back(mk(KIND_SET_KEY, 8'h11, 32'hffff_fff0, 32'd0));
    pending_cmds.push_back(mk(KIND_SET_KEY, 8'haa, 32'd5, 32'd0));
    pending_cmds.push_back(mk(KIND_REMOVE, 8'h00, 32'd0, 32'd0));
    pending_cmds.push_back(mk(KIND_REMOVE, 8'h55, 32'd0, 32'd0));
    pending_cmds.push_back(mk(KIND_DEL_MIN, 8'd0, 32'd0, 32'd0));
    pending_cmds.push_back(mk(KIND_DEL_MIN, 8'd0, 32'd0, 32'd0));
    pending_cmds.push_back(mk(KIND_DEL_MIN, 8'd0, 32'd0, 32'd0));
    pending_cmds.push_back(mk(KIND_DEL_MIN, 8'd0, 32'd0, 32'd0));
    pending_cmds.push_back(mk(KIND_INSERT, 8'd9, 32'd3, 32'd3));
    pending_cmds.push_back(mk(KIND_DEL_MIN, 8'd0, 32'd0, 32'd0));
    drain();

    // Fill to capacity, then hit the full case.
    for (int i = 0; i < CAP + 2; i++)
      pending_cmds.push_back(mk(KIND_INSERT, 8'(i * 3), rand_key(), $urandom()));
    pending_cmds.push_back(mk(KIND_INSERT, 8'd3, 32'd0, 32'd0));
    // Wait until the queue is drained, then pause the sender.
    drain();
    hold_off = 1'b1;
    repeat (3) @(posedge clk);
    hold_off = 1'b0;

    // Random phases: sender idling 24%, then 85%, then never.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 85 : 0;
      for (int n = 0; n < 600; n++)
        pending_cmds.push_back(rand_cmd((n / 100) % 2 ? 25 : 55));
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
